// ===== hw/rtl/ptu_pkg.sv =====
// Shared types, constants and codes of the page translation unit.
`default_nettype none

package ptu_pkg;

	// Geometry of the page store and the physical space
	localparam int PAGE_BYTES  = 128;
	localparam int NUM_FRAMES  = 32;
	localparam int ENTRY_COUNT = 64;

	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

	// Fault codes of a result
	localparam logic [2:0] FLT_NONE = 3'd0;
	localparam logic [2:0] FLT_ADDR = 3'd1;
	localparam logic [2:0] FLT_PAGE = 3'd2;
	localparam logic [2:0] FLT_RO   = 3'd3;
	localparam logic [2:0] FLT_BUS  = 3'd4;

	// Translation modes
	localparam logic MODE_TABLE = 1'b0;
	localparam logic MODE_ASSOC = 1'b1;

	// Register indexes, as seen on paddr[2]
	localparam logic REG_IDX_MODE = 1'b0;
	localparam logic REG_IDX_EIU  = 1'b1;

	typedef enum logic [1:0] {
		FN_XLATE = 2'd0,
		FN_WRITE = 2'd1,
		FN_READ  = 2'd2,
		FN_NONE  = 2'd3
	} func_e_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2
	} size_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOK,
		ST_SCAN,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_VPN,
		RD_FIRST,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FAULT,
		RES_ENTRY,
		RES_PHYS
	} res_sel_t;

	// One page store entry
	typedef struct packed {
		logic        valid;
		logic [24:0] vpage;
		logic [15:0] frame;
		logic        read_only;
		logic        use_bit;
		logic        dirty;
	} entry_t;

	// Input word, highest field first
	typedef struct packed {
		logic [1:0]  pad;
		logic        new_dirty;
		logic        new_use;
		logic        new_read_only;
		logic [15:0] new_frame;
		logic [24:0] new_vpage;
		logic        new_valid;
		logic [5:0]  entry_index;
		logic        is_write;
		logic [1:0]  access_size;
		logic [31:0] virt_addr;
	} in_word_t;

	// Result word, highest field first
	typedef struct packed {
		logic        out_dirty;
		logic        out_use;
		logic        out_read_only;
		logic [15:0] out_frame;
		logic [24:0] out_vpage;
		logic        out_valid;
		logic [15:0] phys_addr;
		logic [2:0]  fault;
	} out_word_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       hit_load;
		logic       wr_item;
		logic       wr_back;
		logic       res_load;
		res_sel_t   res_sel;
		logic [2:0] res_fault;
		logic       out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		func_e_t func;
		logic    mode;
		logic    align_err;
		logic    idx_ok;
		logic    vpn_oob;
		logic    bound_zero;
		logic    rd_valid;
		logic    rd_match;
		logic    scan_last;
		logic    ro_store;
		logic    frame_oob;
		logic    out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptu_dpath.sv =====
// Datapath: item registers, page store, scan pointer, result and output registers.
`default_nettype none

module ptu_dpath
	import ptu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        mode,
	input  wire logic [6:0]  entries_in_use,
	input  wire logic [1:0]  in_func,
	input  wire in_word_t    in_word,
	output out_word_t        out_word,
	output logic             out_valid,
	input  wire logic        out_ready
);

	func_e_t             func_q;
	in_word_t            item_q;
	entry_t              mem [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] ok_q;
	entry_t              rd_s1;
	logic                rd_ok_s1;
	logic [IDX_W-1:0]    raddr_q;
	entry_t              hit_q;
	logic [IDX_W-1:0]    hit_addr_q;
	out_word_t           res_q;
	out_word_t           out_q;
	logic                out_valid_q;

	logic [CNT_W-1:0]    bound;
	logic [31:0]         vpn;
	logic [IDX_W-1:0]    rd_addr;
	entry_t              rd_ent;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic                wr_en;
	out_word_t           res_d;

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_e_t'(in_func);
			item_q <= in_word;
		end
	end

	// Effective store bound and page number
	always_comb begin
		if (32'(entries_in_use) >= ENTRY_COUNT) begin
			bound = CNT_W'(ENTRY_COUNT);
		end else begin
			bound = CNT_W'(entries_in_use);
		end
		vpn = item_q.virt_addr >> OFF_W;
	end

	// Select the read address
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:   rd_addr = IDX_W'(item_q.entry_index);
			RD_VPN:   rd_addr = vpn[IDX_W-1:0];
			RD_FIRST: rd_addr = '0;
			RD_NEXT:  rd_addr = raddr_q + IDX_W'(1);
			default:  rd_addr = '0;
		endcase
	end

	// Registered store read; the address stays as scan pointer
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1    <= mem[rd_addr];
			rd_ok_s1 <= ok_q[rd_addr];
			raddr_q  <= rd_addr;
		end
	end

	// An entry never written reads as all zero
	assign rd_ent = rd_ok_s1 ? rd_s1 : '0;

	// Hold the found entry
	always_ff @(posedge clk) begin
		if (cmd.hit_load) begin
			hit_q      <= rd_ent;
			hit_addr_q <= raddr_q;
		end
	end

	// Store write: a new entry, or the hit entry with use and dirty updated
	always_comb begin
		wr_en = cmd.wr_item | cmd.wr_back;
		if (cmd.wr_back) begin
			wr_addr         = hit_addr_q;
			wr_data         = hit_q;
			wr_data.use_bit = 1'b1;
			wr_data.dirty   = hit_q.dirty | item_q.is_write;
		end else begin
			wr_addr           = IDX_W'(item_q.entry_index);
			wr_data.valid     = item_q.new_valid;
			wr_data.vpage     = item_q.new_vpage;
			wr_data.frame     = item_q.new_frame;
			wr_data.read_only = item_q.new_read_only;
			wr_data.use_bit   = item_q.new_use;
			wr_data.dirty     = item_q.new_dirty;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Written marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= '0;
		end else if (wr_en) begin
			ok_q[wr_addr] <= 1'b1;
		end
	end

	// Build the result
	always_comb begin
		res_d = '0;
		case (cmd.res_sel)
			RES_ZERO: res_d = '0;
			RES_FAULT: res_d.fault = cmd.res_fault;
			RES_ENTRY: begin
				res_d.out_valid     = rd_ent.valid;
				res_d.out_vpage     = rd_ent.vpage;
				res_d.out_frame     = rd_ent.frame;
				res_d.out_read_only = rd_ent.read_only;
				res_d.out_use       = rd_ent.use_bit;
				res_d.out_dirty     = rd_ent.dirty;
			end
			RES_PHYS: begin
				res_d.fault     = FLT_NONE;
				res_d.phys_addr = 16'((32'(hit_q.frame) << OFF_W)
					| 32'(item_q.virt_addr[OFF_W-1:0]));
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= res_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_word  = out_q;
	assign out_valid = out_valid_q;

	// Status toward the controller
	always_comb begin
		sts.func       = func_q;
		sts.mode       = mode;
		sts.align_err  = (size_e_t'(item_q.access_size) == SZ_WORD
				&& item_q.virt_addr[1:0] != 2'b00)
			|| (size_e_t'(item_q.access_size) == SZ_HALF && item_q.virt_addr[0]);
		sts.idx_ok     = 32'(item_q.entry_index) < ENTRY_COUNT;
		sts.vpn_oob    = vpn >= 32'(bound);
		sts.bound_zero = bound == '0;
		sts.rd_valid   = rd_ent.valid;
		sts.rd_match   = rd_ent.valid && (32'(rd_ent.vpage) == vpn);
		sts.scan_last  = (32'(raddr_q) + 32'd1) >= 32'(bound);
		sts.ro_store   = hit_q.read_only && item_q.is_write;
		sts.frame_oob  = 32'(hit_q.frame) >= NUM_FRAMES;
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ptu_ctrl.sv =====
// Controller: sequences decode, store lookup or scan, check and result hand-off.
`default_nettype none

module ptu_ctrl
	import ptu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_DONE;
				if (sts.func == FN_XLATE && !sts.align_err) begin
					if (sts.mode == MODE_TABLE) begin
						if (!sts.vpn_oob) state_d = ST_LOOK;
					end else if (!sts.bound_zero) begin
						state_d = ST_SCAN;
					end
				end else if (sts.func == FN_READ && sts.idx_ok) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.func == FN_XLATE && sts.rd_valid) begin
					state_d = ST_CHECK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (sts.rd_match) begin
					state_d = ST_CHECK;
				end else if (sts.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_CHECK: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_ZERO;
				case (sts.func)
					FN_XLATE: begin
						if (sts.align_err) begin
							cmd.res_sel   = RES_FAULT;
							cmd.res_fault = FLT_ADDR;
						end else if (sts.mode == MODE_TABLE) begin
							if (sts.vpn_oob) begin
								cmd.res_sel   = RES_FAULT;
								cmd.res_fault = FLT_ADDR;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_VPN;
							end
						end else if (sts.bound_zero) begin
							cmd.res_sel   = RES_FAULT;
							cmd.res_fault = FLT_PAGE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_FIRST;
						end
					end
					FN_WRITE: cmd.wr_item = sts.idx_ok;
					FN_READ: begin
						cmd.rd_en  = sts.idx_ok;
						cmd.rd_sel = RD_IDX;
					end
					default: cmd.res_sel = RES_ZERO;
				endcase
			end
			ST_LOOK: begin
				if (sts.func == FN_READ) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ENTRY;
				end else if (sts.rd_valid) begin
					cmd.hit_load = 1'b1;
				end else begin
					cmd.res_load  = 1'b1;
					cmd.res_sel   = RES_FAULT;
					cmd.res_fault = FLT_PAGE;
				end
			end
			ST_SCAN: begin
				if (sts.rd_match) begin
					cmd.hit_load = 1'b1;
				end else if (sts.scan_last) begin
					cmd.res_load  = 1'b1;
					cmd.res_sel   = RES_FAULT;
					cmd.res_fault = FLT_PAGE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_CHECK: begin
				cmd.res_load = 1'b1;
				if (sts.ro_store) begin
					cmd.res_sel   = RES_FAULT;
					cmd.res_fault = FLT_RO;
				end else if (sts.frame_oob) begin
					cmd.res_sel   = RES_FAULT;
					cmd.res_fault = FLT_BUS;
				end else begin
					cmd.res_sel = RES_PHYS;
					cmd.wr_back = 1'b1;
				end
			end
			ST_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/page_translation_unit.sv =====
// Top level: page translation unit with stream ports and APB register port.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tuser func, s_tdata item word
//  m_      | out | m_tvalid / m_tready  | m_tdata result word
//  apb     | in  | psel/penable/pready  | paddr, pwdata, prdata
//
// Steps per word: entry writes, unused codes and alignment or bound faults
// go from decode to done; entry reads and table-mode page faults add a store
// lookup; table-mode translations that find a valid entry add a lookup and a
// check; associative translations scan the entries below the bound until a
// match, one store entry a cycle through the single read port, then check a hit.
// A result waits in the output register while the next word is taken; a
// stalled output holds the word after that in the controller. Reset clears
// the written marks of all entries at once, so no clearing pass follows it.
`default_nettype none

module page_translation_unit
	import ptu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata from bit 0: virt_addr[31:0], access_size[1:0], is_write,
	// entry_index[5:0], new_valid, new_vpage[24:0], new_frame[15:0],
	// new_read_only, new_use, new_dirty, two zero bits
	input  wire logic [87:0] s_tdata,
	// s_tuser from bit 0: func[1:0]
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// m_tdata from bit 0: fault[2:0], phys_addr[15:0], out_valid,
	// out_vpage[24:0], out_frame[15:0], out_read_only, out_use, out_dirty
	output logic [63:0]      m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       mode_q;
	logic [6:0] eiu_q;
	logic       cfg_wr;
	cmd_t       cmd;
	sts_t       sts;
	out_word_t  out_word;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TABLE;
			eiu_q  <= 7'd64;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IDX_MODE) begin
				mode_q <= pwdata[0];
			end else begin
				eiu_q <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_IDX_EIU) begin
			prdata = {25'd0, eiu_q};
		end else begin
			prdata = {31'd0, mode_q};
		end
	end

	ptu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptu_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode_q),
		.entries_in_use (eiu_q),
		.in_func        (s_tuser),
		.in_word        (in_word_t'(s_tdata)),
		.out_word       (out_word),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready)
	);

	assign m_tdata = 64'(out_word);

endmodule

`default_nettype wire

// ===== hw/rtl/ptu_checker.sv =====
// Port-level checker of the page translation unit and its bind.
`default_nettype none

module ptu_checker
	import ptu_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Count words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// No result without a word taken before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result word without an input word");

	// At most one word in work and one waiting at the output
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("too many words in flight");

	// A mode write reads back in the next cycle
	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_IDX_MODE
		|=> !(psel && paddr[2] == REG_IDX_MODE && !pwrite)
			|| prdata[0] == $past(pwdata[0]))
		else $error("mode register read back wrong");

endmodule

bind page_translation_unit ptu_checker u_ptu_checker (.*);

`default_nettype wire

// ===== tb/tb_page_translation_unit.sv =====
// Self-checking testbench of the page translation unit: stream driver, monitor and predictor.

module tb_page_translation_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ptu_pkg::*;

	// Register addresses and the size code with no name in the package
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_LIMIT   = 3'd4;
	localparam logic [1:0] SZ_ODD      = 2'd3;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         HOLD_CYCLES = 400;
	localparam int         TAIL_CYCLES = 80;

	typedef struct {
		in_word_t word;
		func_e_t  fn;
		int       gap;
	} job_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = FN_XLATE;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	wire  [63:0] m_tdata;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	wire  [31:0] prdata;
	wire         pready;

	// Mirror of the block: page store and register copies
	entry_t      page_tab [ENTRY_COUNT];
	logic        xl_mode;
	int          xl_limit;

	job_t        pend_q [$];
	out_word_t   result_q [$];
	job_t        cur_job;
	logic        offer;
	logic        gap_armed;
	int          gap_left;
	int          stall_left;
	int          hold_left;
	logic        take;
	int          tx_gap_max;
	int          rx_stall_max;
	int          hold_asks;
	int          hold_seen;
	int          errors;
	int          cycles;
	int          n_results;
	int          n_fn [4];
	int          n_flt [5];

	page_translation_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out the result of one word and update the mirrored store
	function automatic out_word_t ptu_predict(in_word_t w, func_e_t fn);
		out_word_t         r;
		entry_t            e;
		int                bound;
		int                hit;
		int                i;
		logic [31-OFF_W:0] vpn;
		logic [OFF_W-1:0]  off;
		logic              misalign;
		r = '0;
		case (fn)
			FN_XLATE: begin
				bound = (xl_limit < ENTRY_COUNT) ? xl_limit : ENTRY_COUNT;
				vpn = w.virt_addr[31:OFF_W];
				off = w.virt_addr[OFF_W-1:0];
				misalign = (w.access_size == SZ_WORD && w.virt_addr[1:0] != 2'b00) ||
					(w.access_size == SZ_HALF && w.virt_addr[0]);
				hit = -1;
				if (misalign) begin
					r.fault = FLT_ADDR;
				end else if (xl_mode == MODE_TABLE) begin
					if (vpn >= bound)
						r.fault = FLT_ADDR;
					else if (!page_tab[vpn[IDX_W-1:0]].valid)
						r.fault = FLT_PAGE;
					else
						hit = int'(vpn);
				end else begin
					// lowest matching slot below the bound wins
					for (i = 0; i < bound && hit < 0; i++)
						if (page_tab[i].valid && page_tab[i].vpage == vpn)
							hit = i;
					if (hit < 0)
						r.fault = FLT_PAGE;
				end
				if (hit >= 0) begin
					if (page_tab[hit].read_only && w.is_write) begin
						r.fault = FLT_RO;
					end else if (page_tab[hit].frame >= NUM_FRAMES) begin
						r.fault = FLT_BUS;
					end else begin
						page_tab[hit].use_bit = 1'b1;
						if (w.is_write)
							page_tab[hit].dirty = 1'b1;
						r.phys_addr = 16'(page_tab[hit].frame * PAGE_BYTES + off);
					end
				end
			end
			FN_WRITE: begin
				page_tab[w.entry_index] = {w.new_valid, w.new_vpage, w.new_frame,
					w.new_read_only, w.new_use, w.new_dirty};
			end
			FN_READ: begin
				e = page_tab[w.entry_index];
				r.out_valid     = e.valid;
				r.out_vpage     = e.vpage;
				r.out_frame     = e.frame;
				r.out_read_only = e.read_only;
				r.out_use       = e.use_bit;
				r.out_dirty     = e.dirty;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Queue one word; fields the operation ignores keep random content
	task automatic add_job(func_e_t fn, in_word_t w);
		job_t j;
		j.word = w;
		j.word.pad = '0;
		j.fn = fn;
		j.gap = $urandom_range(0, tx_gap_max);
		pend_q.push_back(j);
	endtask

	function automatic in_word_t noise_word();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[87:0];
	endfunction

	task automatic add_write(logic [IDX_W-1:0] idx, logic v, logic [24:0] vp,
			logic [15:0] fr, logic ro, logic us, logic dt);
		in_word_t w;
		w = noise_word();
		w.entry_index   = idx;
		w.new_valid     = v;
		w.new_vpage     = vp;
		w.new_frame     = fr;
		w.new_read_only = ro;
		w.new_use       = us;
		w.new_dirty     = dt;
		add_job(FN_WRITE, w);
	endtask

	task automatic add_xlate(logic [31:0] va, logic [1:0] sz, logic wr);
		in_word_t w;
		w = noise_word();
		w.virt_addr   = va;
		w.access_size = sz;
		w.is_write    = wr;
		add_job(FN_XLATE, w);
	endtask

	task automatic add_read(logic [IDX_W-1:0] idx);
		in_word_t w;
		w = noise_word();
		w.entry_index = idx;
		add_job(FN_READ, w);
	endtask

	// Small set of pages, at both ends of the page range, so searches hit
	function automatic logic [24:0] pool_vpn();
		logic [24:0] r;
		r = 25'($urandom_range(0, 15));
		return $urandom_range(0, 1) ? (25'h1FFFFF0 | r) : r;
	endfunction

	function automatic logic [IDX_W-1:0] pick_slot(int bound);
		if (bound > 0 && $urandom_range(0, 3) != 0)
			return IDX_W'($urandom_range(0, bound - 1));
		return IDX_W'($urandom_range(0, ENTRY_COUNT - 1));
	endfunction

	// Mostly translations of pages the store holds, plus entry writes, reads, unused codes
	task automatic add_random(int n);
		int                bound;
		int                pick;
		int                k;
		logic [31-OFF_W:0] vpn;
		logic [OFF_W-1:0]  off;
		logic [1:0]        sz;
		logic [24:0]       vp;
		logic [15:0]       fr;
		in_word_t          w;
		bound = (xl_limit < ENTRY_COUNT) ? xl_limit : ENTRY_COUNT;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				vp = (xl_mode == MODE_ASSOC && $urandom_range(0, 4) != 0) ?
					pool_vpn() : 25'($urandom);
				fr = ($urandom_range(0, 3) != 0) ?
					16'($urandom_range(0, NUM_FRAMES - 1)) : 16'($urandom);
				add_write(pick_slot(bound), $urandom_range(0, 99) < 85, vp, fr,
					$urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom));
			end else if (pick < 28) begin
				add_read(pick_slot(bound));
			end else if (pick < 31) begin
				w = noise_word();
				add_job(FN_NONE, w);
			end else begin
				if (xl_mode == MODE_TABLE && $urandom_range(0, 9) < 8)
					vpn = 25'($urandom_range(0, bound));
				else if (xl_mode == MODE_ASSOC && $urandom_range(0, 9) < 8)
					vpn = pool_vpn();
				else
					vpn = 25'($urandom);
				off = OFF_W'($urandom_range(0, PAGE_BYTES - 1));
				sz = 2'($urandom);
				if ($urandom_range(0, 6) != 0) begin
					if (sz == SZ_WORD)
						off[1:0] = 2'b00;
					else if (sz == SZ_HALF)
						off[0] = 1'b0;
				end
				add_xlate({vpn, off}, sz, 1'($urandom));
			end
		end
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_regs(logic mode, int limit);
		apb_write(REG_MODE, {31'b0, mode});
		xl_mode = mode;
		apb_write(REG_LIMIT, 32'(limit));
		xl_limit = limit;
	endtask

	// Hold the sender until every word is out and every result has come
	task automatic drain();
		do @(posedge clk); while (pend_q.size() != 0 || s_tvalid || result_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cmp_field(string nm, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
			errors++;
		end
	endtask

	task automatic check_result(out_word_t want, out_word_t got);
		cmp_field("fault", 32'(want.fault), 32'(got.fault));
		cmp_field("phys_addr", 32'(want.phys_addr), 32'(got.phys_addr));
		cmp_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
		cmp_field("out_vpage", 32'(want.out_vpage), 32'(got.out_vpage));
		cmp_field("out_frame", 32'(want.out_frame), 32'(got.out_frame));
		cmp_field("out_read_only", 32'(want.out_read_only), 32'(got.out_read_only));
		cmp_field("out_use", 32'(want.out_use), 32'(got.out_use));
		cmp_field("out_dirty", 32'(want.out_dirty), 32'(got.out_dirty));
	endtask

	// Driver: offer queued words, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_armed = 1'b0;
			gap_left = 0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				result_q.push_back(ptu_predict(cur_job.word, cur_job.fn));
				n_fn[cur_job.fn]++;
				if (cur_job.fn == FN_XLATE)
					n_flt[result_q[$].fault]++;
				offer = 1'b0;
			end
			if (!offer && pend_q.size() != 0) begin
				if (!gap_armed) begin
					gap_left = pend_q[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					cur_job = pend_q.pop_front();
					s_tdata <= cur_job.word;
					s_tuser <= cur_job.fn;
					offer = 1'b1;
					gap_armed = 1'b0;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Monitor: check each result word, stall the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result word with none expected, actual %0h", $time, m_tdata);
					errors++;
				end else begin
					check_result(result_q.pop_front(), m_tdata);
				end
				n_results++;
				stall_left = $urandom_range(0, rx_stall_max);
			end
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			m_tready <= take;
		end
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, result_q.size());
			$display("tb_page_translation_unit NOT OK");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < ENTRY_COUNT; i++)
			page_tab[i] = '0;
		xl_mode = MODE_TABLE;
		xl_limit = ENTRY_COUNT;
		tx_gap_max = 17;
		rx_stall_max = 17;
		hold_asks = 0;
		hold_seen = 0;
		errors = 0;
		cycles = 0;
		n_results = 0;
		n_fn = '{default: 0};
		n_flt = '{default: 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Table mode: alignment, permissions, frame bound, store bound
		set_regs(MODE_TABLE, ENTRY_COUNT);
		add_read(6'd0);
		add_xlate(32'h0, SZ_BYTE, 1'b0);
		add_write(6'd0, 1'b1, 25'd0, 16'd5, 1'b0, 1'b0, 1'b0);
		add_xlate(32'h3, SZ_BYTE, 1'b0);
		add_xlate(32'h2, SZ_HALF, 1'b1);
		add_xlate(32'h1, SZ_HALF, 1'b0);
		add_xlate(32'h2, SZ_WORD, 1'b0);
		add_xlate(32'h3, SZ_ODD, 1'b0);
		add_read(6'd0);
		add_write(6'd1, 1'b1, 25'd1, 16'd31, 1'b1, 1'b0, 1'b0);
		add_xlate(32'h80, SZ_BYTE, 1'b1);
		add_xlate(32'hFF, SZ_BYTE, 1'b0);
		add_write(6'd2, 1'b1, 25'd2, 16'd32, 1'b0, 1'b0, 1'b0);
		add_xlate(32'h100, SZ_WORD, 1'b0);
		add_write(6'd63, 1'b1, 25'h1FFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		add_read(6'd63);
		add_xlate(32'(63 * PAGE_BYTES), SZ_BYTE, 1'b0);
		add_xlate(32'(64 * PAGE_BYTES), SZ_BYTE, 1'b0);
		add_xlate(32'hFFFFFFFF, SZ_BYTE, 1'b0);
		add_job(FN_NONE, noise_word());
		add_random(200);
		drain();

		// Associative mode: duplicate pages resolve to the lowest slot
		set_regs(MODE_ASSOC, ENTRY_COUNT);
		add_write(6'd5, 1'b1, 25'h1FFFFFF, 16'd7, 1'b0, 1'b0, 1'b0);
		add_write(6'd3, 1'b1, 25'h1FFFFFF, 16'd9, 1'b0, 1'b0, 1'b0);
		add_xlate(32'hFFFFFFFC, SZ_WORD, 1'b1);
		add_read(6'd3);
		add_write(6'd3, 1'b0, 25'h1FFFFFF, 16'd9, 1'b0, 1'b0, 1'b0);
		add_xlate(32'hFFFFFFFE, SZ_HALF, 1'b0);
		add_xlate(32'h0, SZ_BYTE, 1'b0);
		add_random(200);
		drain();

		// Empty store bound in both modes
		set_regs(MODE_ASSOC, 0);
		add_random(40);
		drain();
		set_regs(MODE_TABLE, 0);
		add_random(40);
		drain();

		// Partial bounds; back to back on both sides, then a long output hold
		tx_gap_max = 0;
		rx_stall_max = 0;
		set_regs(MODE_TABLE, $urandom_range(1, ENTRY_COUNT - 1));
		add_random(150);
		drain();
		rx_stall_max = 17;
		set_regs(MODE_ASSOC, $urandom_range(1, ENTRY_COUNT - 1));
		hold_asks++;
		add_random(150);
		drain();

		tx_gap_max = 17;
		set_regs(MODE_ASSOC, 1);
		add_random(80);
		drain();
		tx_gap_max = 0;
		set_regs(MODE_TABLE, ENTRY_COUNT);
		add_random(150);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d results: %0d translations, %0d entry writes, %0d entry reads,",
			n_results, n_fn[FN_XLATE], n_fn[FN_WRITE], n_fn[FN_READ]);
		$display("%0d unused codes; translations ok %0d, addr %0d, page %0d, ro %0d, bus %0d",
			n_fn[FN_NONE], n_flt[FLT_NONE], n_flt[FLT_ADDR], n_flt[FLT_PAGE],
			n_flt[FLT_RO], n_flt[FLT_BUS]);
		if (errors == 0 && result_q.size() == 0)
			$display("tb_page_translation_unit OK");
		else
			$display("tb_page_translation_unit NOT OK");
		$finish;
	end

endmodule
